FILE: rtl/utf8d_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the UTF-8 byte stream decoder.
// Depends on nothing; every rtl module imports it.
package utf8d_pkg;

    // Byte classes and limits
    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD_MIN    = 8'hC0;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD_BAD    = 8'hF8;
    localparam logic [2:0] SEQ_MAX     = 3'd4;
    localparam int         CP_W        = 21;
    localparam int         QUEUE_DEPTH = 2;

    // Input command codes
    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_ESCAPE = 1'b1;

    // Sequence lengths implied by a lead byte
    localparam logic [2:0] NEED_NONE = 3'd0;
    localparam logic [2:0] NEED_2    = 3'd2;
    localparam logic [2:0] NEED_3    = 3'd3;
    localparam logic [2:0] NEED_4    = 3'd4;

    typedef enum logic [1:0] {
        K_ESC,
        K_ASCII,
        K_LEAD,
        K_CONT
    } t_kind;

    // Classified transaction as it travels through the queue
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [2:0] need;
    } t_item;

    // Queue head seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    // Length of the sequence a lead byte opens; NEED_NONE never completes
    function automatic logic [2:0] lead_need(input logic [7:0] b);
        logic [2:0] n;
        begin
            if (b >= LEAD_BAD)       n = NEED_NONE;
            else if (b >= LEAD4_MIN) n = NEED_4;
            else if (b >= LEAD3_MIN) n = NEED_3;
            else                     n = NEED_2;
            return n;
        end
    endfunction

endpackage

FILE: rtl/utf8_byte_stream_decoder.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 byte stream decoder: front end, queue, back end.
// Depends on utf8d_pkg, utf8d_front, utf8d_queue and utf8d_back.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+---------------------------
//   input   | in        | i_valid / o_stall  | i_cmd, i_data_byte
//   output  | out       | o_valid / i_stall  | o_code_point
//
// One transaction per cycle sustained while o_stall is low; the back end
// updates the sequence state as it pops each transaction. A result passes
// through the queue and the output register after its input is accepted.
// Reset (i_rst_n low, synchronous) empties the queue, closes any sequence
// and drops a pending result. o_stall rises only when the queue is full,
// which happens only after the output has been stalled.
module utf8_byte_stream_decoder
    import utf8d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_cmd,
    input  logic [7:0]      i_data_byte,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [CP_W-1:0] o_code_point
);

    logic   w_push;
    logic   w_pop;
    logic   w_full;
    t_item  w_item;
    t_qhead w_head;

    assign o_stall = w_full;

    utf8d_front u_front (
        .i_valid     (i_valid),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_item      (w_item)
    );

    utf8d_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    utf8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_code_point (o_code_point)
    );

endmodule

FILE: rtl/utf8d_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transactions and classifies each byte.
// Depends on utf8d_pkg.
module utf8d_front
    import utf8d_pkg::*;
(
    input  logic       i_valid,
    input  logic       i_cmd,
    input  logic [7:0] i_data_byte,
    input  logic       i_q_full,
    output logic       o_push,
    output t_item      o_item
);

    // Accept whenever the queue has room
    assign o_push = i_valid && !i_q_full;

    // Classify the byte and precompute the lead length
    always_comb begin
        o_item.data = i_data_byte;
        o_item.need = lead_need(i_data_byte);
        if (i_cmd == CMD_ESCAPE) begin
            o_item.kind = K_ESC;
        end else if (i_data_byte <= ASCII_MAX) begin
            o_item.kind = K_ASCII;
        end else if (i_data_byte >= LEAD_MIN) begin
            o_item.kind = K_LEAD;
        end else begin
            o_item.kind = K_CONT;
        end
    end

endmodule

FILE: rtl/utf8d_queue.sv
`timescale 1ns / 1ps
// Small FIFO of classified transactions between front and back end.
// Depends on utf8d_pkg.
module utf8d_queue
    import utf8d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output logic   o_full,
    output t_qhead o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item           r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rd];

    // Advance pointers and occupancy
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store pushed transaction
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("queue pop while empty");

endmodule

FILE: rtl/utf8d_back.sv
`timescale 1ns / 1ps
// Back end: sequence state, code point assembly and output register.
// Depends on utf8d_pkg.
module utf8d_back
    import utf8d_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_qhead          i_head,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [CP_W-1:0] o_code_point
);

    logic [2:0]      r_seq_count, n_seq_count;
    logic [2:0]      r_need, n_need;
    logic [CP_W-1:0] r_acc, n_acc;
    logic            r_out_valid, n_out_valid;
    logic [CP_W-1:0] r_cp, n_cp;
    logic [2:0]      w_count_inc;
    logic [CP_W-1:0] w_acc_cont;
    logic            w_emit;

    assign w_count_inc = r_seq_count + 3'd1;
    assign w_acc_cont  = {r_acc[CP_W-7:0], i_head.item.data[5:0]};

    // Decide whether the head transaction yields a code point
    always_comb begin
        case (i_head.item.kind)
            K_ASCII: w_emit = 1'b1;
            K_CONT:  w_emit = (r_seq_count != 3'd0) && (r_seq_count < SEQ_MAX)
                              && (w_count_inc == r_need);
            default: w_emit = 1'b0;
        endcase
    end

    // Hold the head while a result would land on a stalled output register
    assign o_pop = i_head.valid && !(w_emit && r_out_valid && i_stall);

    // Update sequence state and output register
    always_comb begin
        n_seq_count = r_seq_count;
        n_need      = r_need;
        n_acc       = r_acc;
        n_cp        = r_cp;
        n_out_valid = r_out_valid && i_stall;
        if (o_pop) begin
            case (i_head.item.kind)
                K_ESC: begin
                    n_seq_count = 3'd0;
                end
                K_ASCII: begin
                    n_seq_count = 3'd0;
                    n_cp        = CP_W'(i_head.item.data);
                end
                K_LEAD: begin
                    n_seq_count = 3'd1;
                    n_need      = i_head.item.need;
                    case (i_head.item.need)
                        NEED_2:  n_acc = CP_W'(i_head.item.data[4:0]);
                        NEED_3:  n_acc = CP_W'(i_head.item.data[3:0]);
                        NEED_4:  n_acc = CP_W'(i_head.item.data[2:0]);
                        default: n_acc = '0;
                    endcase
                end
                K_CONT: begin
                    if (w_emit) begin
                        n_seq_count = 3'd0;
                        n_cp        = w_acc_cont;
                    end else if ((r_seq_count != 3'd0) && (r_seq_count < SEQ_MAX)) begin
                        n_seq_count = w_count_inc;
                        n_acc       = w_acc_cont;
                    end
                end
                default: begin
                    n_seq_count = r_seq_count;
                end
            endcase
            if (w_emit) begin
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_count <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq_count <= n_seq_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_need <= n_need;
        r_acc  <= n_acc;
        r_cp   <= n_cp;
    end

    assign o_valid      = r_out_valid;
    assign o_code_point = r_cp;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_count <= SEQ_MAX)
        else $error("sequence count out of range");

    a_emit_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (w_emit || i_head.item.kind == K_ESC)) |=> (r_seq_count == 3'd0))
        else $error("sequence not closed after result or escape");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_cp)))
        else $error("stalled result lost or changed");

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_emit) |=> r_out_valid)
        else $error("result dropped");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_byte_stream_decoder: random and directed byte streams,
// predicted code points compared in order. Depends on utf8d_pkg and the decoder rtl.
module tb;
    import utf8d_pkg::*;

    localparam int PHASE_ITEMS    = 190;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } t_tx;

    logic            i_clk;
    logic            i_rst_n      = 1'b0;
    logic            i_valid      = 1'b0;
    logic            o_stall;
    logic            i_cmd        = CMD_BYTE;
    logic [7:0]      i_data_byte  = 8'h00;
    logic            o_valid;
    logic            i_stall      = 1'b0;
    logic [CP_W-1:0] o_code_point;

    utf8_byte_stream_decoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_code_point (o_code_point)
    );

    t_tx             tx_q[$];
    logic [CP_W-1:0] cp_expect_q[$];
    int unsigned     queued_cnt    = 0;
    int unsigned     accepted_cnt  = 0;
    int unsigned     phase_items   = 0;
    int unsigned     mismatches    = 0;
    int unsigned     idle_cycles   = 0;
    int unsigned     src_idle_pct  = 0;
    int unsigned     sink_stall_pct = 0;
    logic            in_taken      = 1'b0;
    t_tx             next_tx;

    // Predictor state: bytes of the open sequence and how many are held
    logic [7:0]      seq_buf [4];
    logic [2:0]      seq_len = 3'd0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Advance the sequence state by one transaction; flag a finished code point
    task automatic utf8_advance(input logic cmd, input logic [7:0] b,
                                output bit emit, output logic [CP_W-1:0] cp);
        logic [2:0] need;
        emit = 1'b0;
        cp   = '0;
        if (cmd == CMD_ESCAPE) begin
            seq_len = 3'd0;
        end else if (b <= ASCII_MAX) begin
            seq_len = 3'd0;
            emit    = 1'b1;
            cp      = CP_W'(b);
        end else if (b >= LEAD_MIN) begin
            seq_buf[0] = b;
            seq_len    = 3'd1;
        end else if (seq_len != 3'd0 && seq_len < SEQ_MAX) begin
            seq_buf[seq_len[1:0]] = b;
            seq_len = seq_len + 3'd1;
            casez (seq_buf[0])
                8'b110?????: need = 3'd2;
                8'b1110????: need = 3'd3;
                8'b11110???: need = 3'd4;
                default:     need = 3'd0;
            endcase
            if (seq_len == need) begin
                emit = 1'b1;
                case (need)
                    3'd2: cp = CP_W'({seq_buf[0][4:0], seq_buf[1][5:0]});
                    3'd3: cp = CP_W'({seq_buf[0][3:0], seq_buf[1][5:0], seq_buf[2][5:0]});
                    default: cp = {seq_buf[0][2:0], seq_buf[1][5:0], seq_buf[2][5:0],
                                   seq_buf[3][5:0]};
                endcase
                seq_len = 3'd0;
            end
        end
    endtask

    task automatic queue_tx(input logic cmd, input logic [7:0] data);
        t_tx tx;
        tx.cmd  = cmd;
        tx.data = data;
        tx_q.push_back(tx);
        queued_cnt++;
        if (cmd == CMD_BYTE) phase_items++;
    endtask

    task automatic queue_cont(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) queue_tx(CMD_BYTE, 8'($urandom_range(8'hBF, 8'h80)));
    endtask

    task automatic queue_lead(input int unsigned len);
        case (len)
            2: queue_tx(CMD_BYTE, 8'($urandom_range(8'hDF, 8'hC0)));
            3: queue_tx(CMD_BYTE, 8'($urandom_range(8'hEF, 8'hE0)));
            default: queue_tx(CMD_BYTE, 8'($urandom_range(8'hF7, 8'hF0)));
        endcase
    endtask

    // Mostly well-formed sequences, the rest broken ones and noise
    task automatic queue_random_chunk();
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(99);
        len  = $urandom_range(4, 2);
        if (pick < 25) begin
            queue_tx(CMD_BYTE, 8'($urandom_range(8'h7F, 8'h00)));
        end else if (pick < 68) begin
            queue_lead(len);
            queue_cont(len - 1);
        end else if (pick < 74) begin
            queue_cont(1);
        end else if (pick < 81) begin
            queue_tx(CMD_ESCAPE, 8'($urandom_range(255)));
        end else if (pick < 87) begin
            // truncated sequence, cut off by whatever comes next
            queue_lead(len);
            queue_cont($urandom_range(len - 2));
        end else if (pick < 92) begin
            queue_tx(CMD_BYTE, 8'($urandom_range(8'hFF, 8'hF8)));
            queue_cont($urandom_range(5));
        end else if (pick < 96) begin
            queue_lead(4);
            queue_cont(3 + $urandom_range(2, 1));
        end else begin
            queue_tx(CMD_BYTE, 8'($urandom_range(255)));
        end
    endtask

    // Drive the input channel: hold a stalled transaction, else offer the next one
    always @(negedge i_clk) begin
        if (i_valid && !in_taken) begin
            // hold payload until accepted
        end else if (i_rst_n && tx_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            next_tx = tx_q.pop_front();
            i_valid     <= 1'b1;
            i_cmd       <= next_tx.cmd;
            i_data_byte <= next_tx.data;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Drive output back-pressure
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Predict on every accepted input, check every accepted result, count dead cycles
    always @(posedge i_clk) begin
        bit              emit;
        logic [CP_W-1:0] cp;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && (i_valid && !o_stall || o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                accepted_cnt++;
                utf8_advance(i_cmd, i_data_byte, emit, cp);
                if (emit) cp_expect_q.push_back(cp);
            end
            if (o_valid && !i_stall) begin
                if (cp_expect_q.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected code point %h", o_code_point);
                    mismatches++;
                end else begin
                    cp = cp_expect_q.pop_front();
                    if (o_code_point !== cp) begin
                        if (mismatches < MAX_REPORTS)
                            $display("code point mismatch: expected %h, got %h",
                                     cp, o_code_point);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        int ph;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        fork
            begin
                for (ph = 0; ph < 4; ph++) begin
                    case (ph)
                        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                        1: begin src_idle_pct = 79; sink_stall_pct = 0;  end
                        2: begin src_idle_pct = 0;  sink_stall_pct = 79; end
                        default: begin src_idle_pct = 21; sink_stall_pct = 21; end
                    endcase
                    phase_items = 0;
                    if (ph == 0) begin
                        // ASCII extremes, lowest two-byte sequence, highest three- and four-byte ones
                        queue_tx(CMD_BYTE, 8'h00); queue_tx(CMD_BYTE, 8'h7F);
                        queue_tx(CMD_BYTE, 8'hC0); queue_tx(CMD_BYTE, 8'h80);
                        queue_tx(CMD_BYTE, 8'hEF); queue_tx(CMD_BYTE, 8'hBF);
                        queue_tx(CMD_BYTE, 8'hBF);
                        queue_tx(CMD_BYTE, 8'hF7); queue_tx(CMD_BYTE, 8'hBF);
                        queue_tx(CMD_BYTE, 8'hBF); queue_tx(CMD_BYTE, 8'hBF);
                        // stray continuation
                        queue_tx(CMD_BYTE, 8'h80);
                        // lead byte interrupts an open sequence
                        queue_tx(CMD_BYTE, 8'hC2); queue_tx(CMD_BYTE, 8'hE2);
                        queue_tx(CMD_BYTE, 8'h82); queue_tx(CMD_BYTE, 8'hAC);
                        // escape entry drops the open sequence
                        queue_tx(CMD_BYTE, 8'hE2); queue_tx(CMD_ESCAPE, 8'hFF);
                        queue_tx(CMD_BYTE, 8'hAC);
                        // invalid lead fills up and never completes
                        queue_tx(CMD_BYTE, 8'hF8); queue_cont(4);
                        queue_tx(CMD_BYTE, 8'h41);
                    end
                    while (phase_items < PHASE_ITEMS) queue_random_chunk();
                    // hold the sender until every result of this phase is back
                    while (!(accepted_cnt == queued_cnt && cp_expect_q.size() == 0))
                        @(posedge i_clk);
                end
                repeat (TAIL_CYCLES) @(posedge i_clk);
            end
            wait (idle_cycles >= WATCHDOG_LIMIT);
        join_any
        if (idle_cycles < WATCHDOG_LIMIT && mismatches == 0) begin
            $display("utf8_byte_stream_decoder test passed");
        end else begin
            $display("utf8_byte_stream_decoder test failed");
        end
        $finish;
    end

endmodule
